@@ rtl/nmf_pkg.sv @@
// Shared constants, codes and types of the 3x3 neighbour mean filter.
package nmf_pkg;

    // Grid limits
    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int DIM_W        = 11;

    // Sample and sum widths; the mean is the sum divided by eight
    localparam int SAMPLE_W   = 16;
    localparam int MEAN_SHIFT = 3;
    localparam int SUM_W      = SAMPLE_W + MEAN_SHIFT;

    // Result queue
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_MAX_HEIGHT  = 2'd2
    } cfg_reg_e_t;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } kind_e_t;

    // One line store entry: the two rows above the incoming row
    typedef struct packed {
        logic [SAMPLE_W-1:0] upper;
        logic [SAMPLE_W-1:0] middle;
    } line_pair_t;

    localparam int LINE_W = $bits(line_pair_t);

    // Border flags of the window centre travelling down the pipeline
    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
        logic last;
    } nb_pos_t;

    // One result held in the output queue
    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered;
        logic                frame_last;
    } out_item_t;

endpackage

@@ rtl/nmf_in_if.sv @@
// Input channel: valid/ready handshake carrying one pixel or flush request.
interface nmf_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [nmf_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink   (input valid, input kind, input sample, output ready);
endinterface

@@ rtl/nmf_out_if.sv @@
// Output channel: valid/ready handshake carrying one filtered sample.
interface nmf_out_if;
    logic                          valid;
    logic                          ready;
    logic [nmf_pkg::SAMPLE_W-1:0]  filtered;
    logic                          frame_last;

    modport source (output valid, output filtered, output frame_last, input ready);
    modport sink   (input valid, input filtered, input frame_last, output ready);
endinterface

@@ rtl/nmf_ram.sv @@
// Generic single-clock RAM: one write port, one read port with registered data.
module nmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata <= mem_reg[raddr];
    end

endmodule

@@ rtl/nmf_out_queue.sv @@
// Result queue: decouples the filter pipeline from the output handshake.
module nmf_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  nmf_pkg::out_item_t push_item,
    nmf_out_if.source          results
);

    nmf_pkg::out_item_t                  q_reg [nmf_pkg::OUTQ_DEPTH];
    logic [nmf_pkg::OUTQ_PTR_W-1:0]      wr_ptr_reg;
    logic [nmf_pkg::OUTQ_PTR_W-1:0]      wr_ptr_next;
    logic [nmf_pkg::OUTQ_PTR_W-1:0]      rd_ptr_reg;
    logic [nmf_pkg::OUTQ_PTR_W-1:0]      rd_ptr_next;
    logic [nmf_pkg::OUTQ_CNT_W-1:0]      count_reg;
    logic [nmf_pkg::OUTQ_CNT_W-1:0]      count_next;
    logic                                pop;

    // Head of queue drives the port
    assign results.valid      = (count_reg != '0);
    assign results.filtered   = q_reg[rd_ptr_reg].filtered;
    assign results.frame_last = q_reg[rd_ptr_reg].frame_last;
    assign pop                = results.valid && results.ready;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + nmf_pkg::OUTQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + nmf_pkg::OUTQ_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + nmf_pkg::OUTQ_CNT_W'(push) - nmf_pkg::OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_item;
        end
    end

    // The credit count upstream must never let the queue overflow
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < nmf_pkg::OUTQ_CNT_W'(nmf_pkg::OUTQ_DEPTH)))
        else $error("result queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !pop)
        else $error("result queue read while empty");

endmodule

@@ rtl/neighbor_mean_filter_3x3_top.sv @@
// Top level of the 3x3 neighbour mean filter (centre excluded, divide by eight, clamp).
// Takes one request per clock: a pixel in raster order or a flush. Each result is the sum
// of the eight neighbours (zero outside the grid) shifted right by three and clamped to
// max_height; results trail the input by one row plus one sample, and after the last
// pixel each flush (or pixel) releases one more result. Both earlier rows live in one
// 1024 x 32 line store that is read, updated and written back every sample, with
// forwarding when the same column is touched in consecutive cycles. Each result passes
// the line store, sum and clamp stage registers and the result queue before it leaves.
// The input stalls while eight results are in flight or queued, and for one cycle after
// the last pixel of a single-row frame, where an extra column is pushed through the line
// store. There is no clearing pass after reset: line store entries not yet written only
// reach masked neighbours. A write to one of the three config registers aborts the frame.
module neighbor_mean_filter_3x3_top (
    input  logic                           clk,
    input  logic                           rst_n,
    nmf_in_if.sink                         samples,
    nmf_out_if.source                      results,
    input  logic                           cfg_we,
    input  logic [nmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nmf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration
    logic [nmf_pkg::DIM_W-1:0]    grid_width_reg;
    logic [nmf_pkg::DIM_W-1:0]    grid_height_reg;
    logic [nmf_pkg::SAMPLE_W-1:0] max_height_reg;
    logic                         cfg_hit;
    logic [nmf_pkg::COL_W-1:0]    w_last;
    logic [nmf_pkg::ROW_W-1:0]    h_last;

    // Input position, output position, frame control
    logic [nmf_pkg::COL_W-1:0]    col_reg;
    logic [nmf_pkg::COL_W-1:0]    col_next;
    logic [nmf_pkg::ROW_W-1:0]    row_reg;
    logic [nmf_pkg::ROW_W-1:0]    row_next;
    logic [nmf_pkg::COL_W-1:0]    ocol_reg;
    logic [nmf_pkg::COL_W-1:0]    ocol_next;
    logic [nmf_pkg::ROW_W-1:0]    orow_reg;
    logic [nmf_pkg::ROW_W-1:0]    orow_next;
    logic                         draining_reg;
    logic                         draining_next;
    logic                         extra_reg;
    logic                         extra_next;
    logic [nmf_pkg::OUTQ_CNT_W-1:0] pending_reg;
    logic [nmf_pkg::OUTQ_CNT_W-1:0] pending_next;

    // Accept stage
    logic                         acc;
    logic                         pop;
    logic                         adv_a;
    logic                         emit_a;
    logic [nmf_pkg::SAMPLE_W-1:0] v_a;
    nmf_pkg::nb_pos_t             pos_a;
    logic                         col_at_end;
    logic                         row_at_end;

    // Line store stage
    logic                         s1_adv_reg;
    logic                         s1_emit_reg;
    logic                         s1_fwd_reg;
    logic                         s1_fwd_next;
    logic [nmf_pkg::SAMPLE_W-1:0] s1_v_reg;
    logic [nmf_pkg::COL_W-1:0]    s1_addr_reg;
    nmf_pkg::nb_pos_t             s1_pos_reg;
    nmf_pkg::line_pair_t          ram_rdata;
    nmf_pkg::line_pair_t          ram_wdata;
    nmf_pkg::line_pair_t          rd_eff;
    nmf_pkg::line_pair_t          fwd_data_reg;
    logic [nmf_pkg::SAMPLE_W-1:0] win_reg [3][3];

    // Sum stage
    logic                         s2_emit_reg;
    nmf_pkg::nb_pos_t             s2_pos_reg;
    logic [2:0]                   row_en;
    logic [2:0]                   col_en;
    logic [nmf_pkg::SUM_W-1:0]    sum_d;

    // Clamp stage
    logic                         s3_valid_reg;
    logic                         s3_last_reg;
    logic [nmf_pkg::SUM_W-1:0]    s3_sum_reg;
    logic [nmf_pkg::SAMPLE_W-1:0] mean;
    nmf_pkg::out_item_t           push_item;

    // ---------------------------------------------------------------- configuration
    assign cfg_hit = cfg_we && ((cfg_index == nmf_pkg::REG_GRID_WIDTH)
                             || (cfg_index == nmf_pkg::REG_GRID_HEIGHT)
                             || (cfg_index == nmf_pkg::REG_MAX_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= nmf_pkg::DIM_W'(nmf_pkg::MAX_WIDTH);
            grid_height_reg <= nmf_pkg::DIM_W'(nmf_pkg::HEIGHT_LIMIT);
            max_height_reg  <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nmf_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata[nmf_pkg::DIM_W-1:0];
                nmf_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata[nmf_pkg::DIM_W-1:0];
                nmf_pkg::REG_MAX_HEIGHT:  max_height_reg  <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    // Last column and row in use; zero means one, oversize saturates
    always_comb
    begin
        priority if (grid_width_reg == '0)
            w_last = '0;
        else if (grid_width_reg > nmf_pkg::DIM_W'(nmf_pkg::MAX_WIDTH))
            w_last = nmf_pkg::COL_W'(nmf_pkg::MAX_WIDTH - 1);
        else
            w_last = nmf_pkg::COL_W'(grid_width_reg - nmf_pkg::DIM_W'(1));

        priority if (grid_height_reg == '0)
            h_last = '0;
        else if (grid_height_reg > nmf_pkg::DIM_W'(nmf_pkg::HEIGHT_LIMIT))
            h_last = nmf_pkg::ROW_W'(nmf_pkg::HEIGHT_LIMIT - 1);
        else
            h_last = nmf_pkg::ROW_W'(grid_height_reg - nmf_pkg::DIM_W'(1));
    end

    // ---------------------------------------------------------------- accept stage
    assign samples.ready = !extra_reg
                        && (pending_reg < nmf_pkg::OUTQ_CNT_W'(nmf_pkg::OUTQ_DEPTH));
    assign acc        = samples.valid && samples.ready;
    assign pop        = results.valid && results.ready;
    assign col_at_end = (col_reg == w_last);
    assign row_at_end = (row_reg == h_last);

    // Border flags of the position about to be emitted
    always_comb
    begin
        pos_a.up    = (orow_reg != '0);
        pos_a.down  = (orow_reg != h_last);
        pos_a.left  = (ocol_reg != '0);
        pos_a.right = (ocol_reg != w_last);
        pos_a.last  = !pos_a.down && !pos_a.right;
    end

    // Decide what the request does: advance the window, emit a result, or nothing
    always_comb
    begin
        adv_a         = 1'b0;
        emit_a        = 1'b0;
        v_a           = samples.sample;
        col_next      = col_reg;
        row_next      = row_reg;
        ocol_next     = ocol_reg;
        orow_next     = orow_reg;
        draining_next = draining_reg;
        extra_next    = extra_reg;

        priority if (extra_reg)
        begin
            // single-row frame: one more virtual column before the first result
            adv_a      = 1'b1;
            v_a        = '0;
            extra_next = 1'b0;
        end
        else if (acc && draining_reg)
        begin
            // flush, or a pixel standing in for one
            adv_a  = 1'b1;
            emit_a = 1'b1;
            v_a    = '0;
        end
        else if (acc && (samples.kind == nmf_pkg::KIND_PIXEL))
        begin
            adv_a  = 1'b1;
            emit_a = (row_reg > nmf_pkg::ROW_W'(1))
                  || ((row_reg == nmf_pkg::ROW_W'(1)) && (col_reg != '0));
            if (row_at_end && col_at_end)
            begin
                draining_next = 1'b1;
                extra_next    = (h_last == '0);
            end
        end
        else
        begin
            adv_a = 1'b0;
        end

        // input position
        if (adv_a)
        begin
            col_next = col_at_end ? '0 : col_reg + nmf_pkg::COL_W'(1);
            if (col_at_end && !draining_reg)
            begin
                row_next = row_reg + nmf_pkg::ROW_W'(1);
            end
        end

        // output position; the frame's final result restarts everything
        if (emit_a)
        begin
            if (pos_a.last)
            begin
                col_next      = '0;
                row_next      = '0;
                ocol_next     = '0;
                orow_next     = '0;
                draining_next = 1'b0;
                extra_next    = 1'b0;
            end
            else if (!pos_a.right)
            begin
                ocol_next = '0;
                orow_next = orow_reg + nmf_pkg::ROW_W'(1);
            end
            else
            begin
                ocol_next = ocol_reg + nmf_pkg::COL_W'(1);
            end
        end
    end

    assign pending_next = pending_reg + nmf_pkg::OUTQ_CNT_W'(emit_a)
                        - nmf_pkg::OUTQ_CNT_W'(pop);

    // Read issued now collides with the write of the stage ahead
    assign s1_fwd_next = adv_a && s1_adv_reg && (s1_addr_reg == col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            ocol_reg     <= '0;
            orow_reg     <= '0;
            draining_reg <= 1'b0;
            extra_reg    <= 1'b0;
            pending_reg  <= '0;
            s1_adv_reg   <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else if (cfg_hit)
        begin
            // new geometry or clamp: abort the frame
            col_reg      <= '0;
            row_reg      <= '0;
            ocol_reg     <= '0;
            orow_reg     <= '0;
            draining_reg <= 1'b0;
            extra_reg    <= 1'b0;
            pending_reg  <= pending_next;
            s1_adv_reg   <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            ocol_reg     <= ocol_next;
            orow_reg     <= orow_next;
            draining_reg <= draining_next;
            extra_reg    <= extra_next;
            pending_reg  <= pending_next;
            s1_adv_reg   <= adv_a;
            s1_emit_reg  <= emit_a;
            s1_fwd_reg   <= s1_fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_v_reg    <= v_a;
        s1_addr_reg <= col_reg;
        s1_pos_reg  <= pos_a;
    end

    // ---------------------------------------------------------------- line store stage
    nmf_ram #(
        .WIDTH (nmf_pkg::LINE_W),
        .DEPTH (nmf_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_adv_reg),
        .waddr (s1_addr_reg),
        .wdata (ram_wdata),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // Read-modify-write: middle moves up, the new value becomes middle
    assign rd_eff           = s1_fwd_reg ? fwd_data_reg : ram_rdata;
    assign ram_wdata.upper  = rd_eff.middle;
    assign ram_wdata.middle = s1_v_reg;

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= ram_wdata;
        if (s1_adv_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= rd_eff.upper;
            win_reg[1][2] <= rd_eff.middle;
            win_reg[2][2] <= s1_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_emit_reg <= 1'b0;
        end
        else
        begin
            s2_emit_reg <= s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_pos_reg <= s1_pos_reg;
    end

    // ---------------------------------------------------------------- sum stage
    assign row_en = {s2_pos_reg.down, 1'b1, s2_pos_reg.up};
    assign col_en = {s2_pos_reg.right, 1'b1, s2_pos_reg.left};

    // Eight neighbours, centre left out, outside positions masked
    always_comb
    begin
        sum_d = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (!((r == 1) && (c == 1)) && row_en[r] && col_en[c])
                begin
                    sum_d = sum_d + nmf_pkg::SUM_W'(win_reg[r][c]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_sum_reg  <= sum_d;
        s3_last_reg <= s2_pos_reg.last;
    end

    // ---------------------------------------------------------------- clamp and queue
    assign mean                 = s3_sum_reg[nmf_pkg::SUM_W-1:nmf_pkg::MEAN_SHIFT];
    assign push_item.filtered   = (mean > max_height_reg) ? max_height_reg : mean;
    assign push_item.frame_last = s3_last_reg;

    nmf_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_valid_reg),
        .push_item (push_item),
        .results   (results)
    );

    // ---------------------------------------------------------------- checks
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= nmf_pkg::OUTQ_CNT_W'(nmf_pkg::OUTQ_DEPTH))
        else $error("more results in flight than the queue can hold");

    a_extra_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        extra_reg |-> draining_reg)
        else $error("extra column outside the drain phase");

    a_extra_single: assert property (@(posedge clk) disable iff (!rst_n)
        extra_reg |=> !extra_reg)
        else $error("extra column lasted more than one cycle");

    a_emit_advances: assert property (@(posedge clk) disable iff (!rst_n)
        s1_emit_reg |-> s1_adv_reg)
        else $error("result emitted without a window advance");

    a_pipe_to_queue: assert property (@(posedge clk) disable iff (!rst_n)
        s2_emit_reg |=> s3_valid_reg)
        else $error("result lost between sum and clamp stages");

endmodule
